// ===== sv/ray_box_slab_intersection_core_assert.svh =====
// assertion macros for the ray box slab test rtl
`ifndef RAY_BOX_SLAB_INTERSECTION_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_CORE_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define RBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rbs assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define RBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rbs assertion failed");

`endif

// ===== sv/rbs_pkg.sv =====
// shared constants and types for the ray box slab test
package rbs_pkg;

    localparam int AXES      = 3;
    localparam int MAX_AXES  = 3;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 16;
    localparam int EPS_W     = 15;
    localparam int DIR_FRAC  = 14;
    localparam int MAG_W     = COORD_W;
    localparam int NUM_W     = MAG_W + DIR_FRAC;
    localparam int DEN_W     = DIR_W;
    localparam int QUO_W     = NUM_W + 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    localparam logic signed [QUO_W-1:0] T_MAX =
        {{(QUO_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [QUO_W-1:0] T_MIN =
        {{(QUO_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] OUT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] OUT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic              par;
        logic              pmiss;
        logic              neg_lo;
        logic              neg_hi;
        logic [MAG_W-1:0]  mag_lo;
        logic [MAG_W-1:0]  mag_hi;
        logic [DEN_W-1:0]  den;
    } rbs_axis_t;

    typedef rbs_axis_t [MAX_AXES-1:0] rbs_item_t;

    typedef struct packed {
        logic par;
        logic pmiss;
        logic neg_lo;
        logic neg_hi;
    } rbs_side_t;

    typedef rbs_side_t [MAX_AXES-1:0] rbs_sides_t;

endpackage

// ===== sv/rbs_fifo.sv =====
// two-entry queue between the classify front and the divide back
module rbs_fifo import rbs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  rbs_item_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output rbs_item_t head
);

    rbs_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/rbs_front.sv =====
// input stage: epsilon register, slab offsets, parallel classification
module rbs_front import rbs_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [EPS_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] origin [MAX_AXES],
    input  logic signed [DIR_W-1:0]   dir    [MAX_AXES],
    input  logic signed [COORD_W-1:0] box_lo [MAX_AXES],
    input  logic signed [COORD_W-1:0] box_hi [MAX_AXES],
    output logic                      item_valid,
    output rbs_item_t                 item,
    input  logic                      item_ready
);

    logic [EPS_W-1:0]  eps_reg;
    logic              front_valid_reg, front_valid_next;
    rbs_item_t         item_reg, item_next;
    logic [COORD_W:0]  diff_lo [MAX_AXES];
    logic [COORD_W:0]  diff_hi [MAX_AXES];
    logic [DIR_W-1:0]  dabs    [MAX_AXES];
    logic              accept;

    assign s_ready    = !front_valid_reg || item_ready;
    assign accept     = s_valid && s_ready;
    assign item_valid = front_valid_reg;
    assign item       = item_reg;

    always_comb begin
        item_next = '0;
        for (int a = 0; a < MAX_AXES; a++) begin
            diff_lo[a] = {box_lo[a][COORD_W-1], box_lo[a]} - {origin[a][COORD_W-1], origin[a]};
            diff_hi[a] = {box_hi[a][COORD_W-1], box_hi[a]} - {origin[a][COORD_W-1], origin[a]};
            dabs[a]    = dir[a][DIR_W-1] ? DIR_W'(-dir[a]) : DIR_W'(dir[a]);
            if (a < AXES) begin
                item_next[a].par    = (dir[a] == '0) || (dabs[a] < {1'b0, eps_reg});
                item_next[a].pmiss  = item_next[a].par
                                      && ((origin[a] < box_lo[a]) || (origin[a] > box_hi[a]));
                item_next[a].neg_lo = diff_lo[a][COORD_W] ^ dir[a][DIR_W-1];
                item_next[a].neg_hi = diff_hi[a][COORD_W] ^ dir[a][DIR_W-1];
                item_next[a].mag_lo = diff_lo[a][COORD_W] ? MAG_W'(~diff_lo[a] + 1'b1)
                                                          : MAG_W'(diff_lo[a]);
                item_next[a].mag_hi = diff_hi[a][COORD_W] ? MAG_W'(~diff_hi[a] + 1'b1)
                                                          : MAG_W'(diff_hi[a]);
                item_next[a].den    = dabs[a];
            end else begin
                item_next[a].par = 1'b1;
            end
        end
        front_valid_next = accept || (front_valid_reg && !item_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg         <= EPS_RESET;
            front_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                eps_reg <= cfg_wr_data;
            end
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/rbs_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage
module rbs_div_lane import rbs_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_step
        logic [DEN_W-1:0] rem_src;
        logic [NUM_W-1:0] nq_src;
        logic [DEN_W-1:0] den_src;
        logic [DEN_W:0]   r2;
        logic [DEN_W:0]   r2_sub;
        logic             ge;

        if (s == 0) begin : g_first
            assign rem_src = '0;
            assign nq_src  = num;
            assign den_src = den;
        end else begin : g_next
            assign rem_src = rem_reg[s-1];
            assign nq_src  = nq_reg[s-1];
            assign den_src = den_reg[s-1];
        end

        assign r2     = {rem_src, nq_src[NUM_W-1]};
        assign ge     = r2 >= {1'b0, den_src};
        assign r2_sub = r2 - {1'b0, den_src};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= ge ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
                nq_reg[s]  <= {nq_src[NUM_W-2:0], ge};
                den_reg[s] <= den_src;
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

// ===== sv/rbs_back.sv =====
// divide, order, narrow and saturate stages with the result register
`include "ray_box_slab_intersection_core_assert.svh"

module rbs_back import rbs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  rbs_item_t          in_item,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [COORD_W-1:0] m_t_near,
    output logic [COORD_W-1:0] m_t_far,
    output logic               m_saturated
);

    logic                      advance;
    logic [NUM_W-1:0]          dv_reg;
    rbs_sides_t                side_reg [NUM_W];
    rbs_sides_t                side_in;
    logic [NUM_W-1:0]          quo_lo [MAX_AXES];
    logic [NUM_W-1:0]          quo_hi [MAX_AXES];
    logic signed [QUO_W-1:0]   q_lo   [MAX_AXES];
    logic signed [QUO_W-1:0]   q_hi   [MAX_AXES];

    logic                      a_valid_reg;
    logic signed [QUO_W-1:0]   a_tmin_reg [MAX_AXES];
    logic signed [QUO_W-1:0]   a_tmax_reg [MAX_AXES];
    logic [MAX_AXES-1:0]       a_par_reg;
    logic [MAX_AXES-1:0]       a_pmiss_reg;

    logic                      b_valid_reg;
    logic signed [QUO_W-1:0]   b_near_reg, b_near_next;
    logic signed [QUO_W-1:0]   b_far_reg, b_far_next;
    logic                      b_bnd_reg, b_bnd_next;
    logic                      b_pmiss_reg;

    logic                      m_valid_reg;
    logic                      hit_reg, hit_next;
    logic [COORD_W-1:0]        near_reg, near_next;
    logic [COORD_W-1:0]        far_reg, far_next;
    logic                      sat_reg, sat_next;

    assign advance  = !m_valid_reg || m_ready;
    assign in_ready = advance;

    always_comb begin
        for (int a = 0; a < MAX_AXES; a++) begin
            side_in[a].par    = in_item[a].par;
            side_in[a].pmiss  = in_item[a].pmiss;
            side_in[a].neg_lo = in_item[a].neg_lo;
            side_in[a].neg_hi = in_item[a].neg_hi;
        end
    end

    for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis
        if (a < AXES) begin : g_lane
            rbs_div_lane u_div_lo (
                .aclk (aclk),
                .en   (advance),
                .num  ({in_item[a].mag_lo, {DIR_FRAC{1'b0}}}),
                .den  (in_item[a].den),
                .quo  (quo_lo[a])
            );
            rbs_div_lane u_div_hi (
                .aclk (aclk),
                .en   (advance),
                .num  ({in_item[a].mag_hi, {DIR_FRAC{1'b0}}}),
                .den  (in_item[a].den),
                .quo  (quo_hi[a])
            );
        end else begin : g_none
            assign quo_lo[a] = '0;
            assign quo_hi[a] = '0;
        end
    end

    // sideband rides along with the divider steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
        end else if (advance) begin
            dv_reg <= {dv_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg[0] <= side_in;
            for (int s = 1; s < NUM_W; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // signed slab distances, ordered per axis
    always_comb begin
        for (int a = 0; a < MAX_AXES; a++) begin
            q_lo[a] = side_reg[NUM_W-1][a].neg_lo ? -$signed({1'b0, quo_lo[a]})
                                                  : $signed({1'b0, quo_lo[a]});
            q_hi[a] = side_reg[NUM_W-1][a].neg_hi ? -$signed({1'b0, quo_hi[a]})
                                                  : $signed({1'b0, quo_hi[a]});
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int a = 0; a < MAX_AXES; a++) begin
                a_tmin_reg[a]  <= (q_lo[a] > q_hi[a]) ? q_hi[a] : q_lo[a];
                a_tmax_reg[a]  <= (q_lo[a] > q_hi[a]) ? q_lo[a] : q_hi[a];
                a_par_reg[a]   <= side_reg[NUM_W-1][a].par;
                a_pmiss_reg[a] <= side_reg[NUM_W-1][a].pmiss;
            end
        end
    end

    // interval narrowing over the bounding axes
    always_comb begin
        b_near_next = '0;
        b_far_next  = '0;
        b_bnd_next  = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            if (!a_par_reg[a]) begin
                if (!b_bnd_next || a_tmin_reg[a] > b_near_next) begin
                    b_near_next = a_tmin_reg[a];
                end
                if (!b_bnd_next || a_tmax_reg[a] < b_far_next) begin
                    b_far_next = a_tmax_reg[a];
                end
                b_bnd_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_near_reg  <= b_near_next;
            b_far_reg   <= b_far_next;
            b_bnd_reg   <= b_bnd_next;
            b_pmiss_reg <= |a_pmiss_reg;
        end
    end

    // hit decision and saturation
    always_comb begin
        hit_next  = !(b_pmiss_reg || (b_bnd_reg && (b_near_reg > b_far_reg)));
        near_next = '0;
        far_next  = '0;
        sat_next  = 1'b0;
        if (hit_next) begin
            if (!b_bnd_reg) begin
                near_next = OUT_MIN;
                far_next  = OUT_MAX;
                sat_next  = 1'b1;
            end else begin
                if (b_near_reg > T_MAX) begin
                    near_next = OUT_MAX;
                    sat_next  = 1'b1;
                end else if (b_near_reg < T_MIN) begin
                    near_next = OUT_MIN;
                    sat_next  = 1'b1;
                end else begin
                    near_next = b_near_reg[COORD_W-1:0];
                end
                if (b_far_reg > T_MAX) begin
                    far_next = OUT_MAX;
                    sat_next = 1'b1;
                end else if (b_far_reg < T_MIN) begin
                    far_next = OUT_MIN;
                    sat_next = 1'b1;
                end else begin
                    far_next = b_far_reg[COORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= dv_reg[NUM_W-1];
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg  <= hit_next;
            near_reg <= near_next;
            far_reg  <= far_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = hit_reg;
    assign m_t_near    = near_reg;
    assign m_t_far     = far_reg;
    assign m_saturated = sat_reg;

    `RBS_ASSERT_IMP(a_miss_zero, m_valid_reg && !hit_reg,
        (near_reg == '0) && (far_reg == '0) && !sat_reg)
    `RBS_ASSERT_IMP(a_hit_order, m_valid_reg && hit_reg,
        $signed(near_reg) <= $signed(far_reg))
    `RBS_ASSERT_NEXT(a_stall_hold, !advance,
        $stable({dv_reg, a_valid_reg, b_valid_reg, m_valid_reg}))

endmodule

// ===== sv/ray_box_slab_intersection_core.sv =====
// top level of the ray versus axis-aligned box slab test
// Slab test of a line against an axis-aligned box in Q16.16, one beat per clock on
// each side when neither side stalls. An accepted beat is classified in the input stage,
// waits in a two-entry queue, then runs through two 46-step pipelined restoring
// dividers per axis followed by ordering, narrowing and saturation stages. The epsilon
// register resets to 1 and must be written only while the block is idle.
module ray_box_slab_intersection_core import rbs_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [EPS_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_origin_x,
    input  logic signed [COORD_W-1:0] s_origin_y,
    input  logic signed [COORD_W-1:0] s_origin_z,
    input  logic signed [DIR_W-1:0]   s_dir_x,
    input  logic signed [DIR_W-1:0]   s_dir_y,
    input  logic signed [DIR_W-1:0]   s_dir_z,
    input  logic signed [COORD_W-1:0] s_box_lo_x,
    input  logic signed [COORD_W-1:0] s_box_lo_y,
    input  logic signed [COORD_W-1:0] s_box_lo_z,
    input  logic signed [COORD_W-1:0] s_box_hi_x,
    input  logic signed [COORD_W-1:0] s_box_hi_y,
    input  logic signed [COORD_W-1:0] s_box_hi_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic signed [COORD_W-1:0] m_t_near,
    output logic signed [COORD_W-1:0] m_t_far,
    output logic                      m_saturated
);

    logic signed [COORD_W-1:0] origin [MAX_AXES];
    logic signed [DIR_W-1:0]   dir    [MAX_AXES];
    logic signed [COORD_W-1:0] box_lo [MAX_AXES];
    logic signed [COORD_W-1:0] box_hi [MAX_AXES];
    logic                      front_valid;
    rbs_item_t                 front_item;
    logic                      fifo_full;
    logic                      fifo_not_empty;
    rbs_item_t                 fifo_head;
    logic                      back_ready;
    logic [COORD_W-1:0]        t_near_bits;
    logic [COORD_W-1:0]        t_far_bits;

    assign origin[0] = s_origin_x;
    assign origin[1] = s_origin_y;
    assign origin[2] = s_origin_z;
    assign dir[0]    = s_dir_x;
    assign dir[1]    = s_dir_y;
    assign dir[2]    = s_dir_z;
    assign box_lo[0] = s_box_lo_x;
    assign box_lo[1] = s_box_lo_y;
    assign box_lo[2] = s_box_lo_z;
    assign box_hi[0] = s_box_hi_x;
    assign box_hi[1] = s_box_hi_y;
    assign box_hi[2] = s_box_hi_z;

    rbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .origin      (origin),
        .dir         (dir),
        .box_lo      (box_lo),
        .box_hi      (box_hi),
        .item_valid  (front_valid),
        .item        (front_item),
        .item_ready  (!fifo_full)
    );

    rbs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_data (front_item),
        .full      (fifo_full),
        .pop       (back_ready),
        .not_empty (fifo_not_empty),
        .head      (fifo_head)
    );

    rbs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (fifo_not_empty),
        .in_item     (fifo_head),
        .in_ready    (back_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_t_near    (t_near_bits),
        .m_t_far     (t_far_bits),
        .m_saturated (m_saturated)
    );

    assign m_t_near = $signed(t_near_bits);
    assign m_t_far  = $signed(t_far_bits);

endmodule
